/* src/lfd_pkg.sv */
// Package for the LED frame stream deframer.
// Holds the controller state, result kinds and the command/status structs.
// No dependencies.
`default_nettype none

package lfd_pkg;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_LENGTH,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        KIND_PIXEL   = 3'd0,
        KIND_VERSION = 3'd1,
        KIND_SCALE   = 3'd2,
        KIND_LENGTH  = 3'd3,
        KIND_TOOLONG = 3'd4
    } t_kind;

    typedef struct packed {
        logic  load_scale;
        logic  load_length;
        logic  load_red;
        logic  load_green;
        logic  load_blue;
        logic  emit_pixel;
        logic  emit_error;
        t_kind err_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic version_ok;
        logic scale_zero;
        logic length_zero;
        logic too_long;
        logic pix_last;
        logic final_pixel;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* src/lfd_if.sv */
// Valid/ready channel interfaces for the deframer: stream bytes in, results out.
// No dependencies.
`default_nettype none

interface lfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface lfd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
    logic       last;

    modport source (output valid, output kind, output led_index, output red, output green,
                    output blue, output frame_done, output last, input ready);
    modport sink (input valid, input kind, input led_index, input red, input green,
                  input blue, input frame_done, input last, output ready);
endinterface

`default_nettype wire

/* src/lfd_datapath.sv */
// Deframer datapath: version register, frame counters, held colors, result register.
// Depends on lfd_pkg.
`default_nettype none

module lfd_datapath #(
    parameter int LED_COUNT = 128
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire  [3:0]           i_cfg_wr_data,
    input  wire  [7:0]           i_stream_byte,
    input  wire                  i_out_ready,
    input  lfd_pkg::t_dp_cmd     i_cmd,
    output lfd_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    output logic [2:0]           o_kind,
    output logic [6:0]           o_led_index,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic                 o_frame_done,
    output logic                 o_last
);

    localparam int CntW = $clog2(LED_COUNT + 1);
    localparam int CmpW = (CntW > 12) ? CntW : 12;

    logic [3:0]    r_version;
    logic [3:0]    r_scale;
    logic [7:0]    r_pixels_left;
    logic [6:0]    r_base;
    logic [3:0]    r_cnt;
    logic [7:0]    r_red_hold;
    logic [7:0]    r_green_hold;
    logic [7:0]    r_blue_hold;
    logic          r_out_valid;
    lfd_pkg::t_kind r_kind;
    logic [6:0]    r_index;
    logic [7:0]    r_red;
    logic [7:0]    r_green;
    logic [7:0]    r_blue;
    logic          r_done;
    logic          r_last;

    logic [CmpW-1:0] prod;
    logic            out_free;

    assign prod     = CmpW'(i_stream_byte) * CmpW'(r_scale);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.version_ok  = (i_stream_byte[7:4] == r_version);
        o_status.scale_zero  = (i_stream_byte[3:0] == 4'd0);
        o_status.length_zero = (i_stream_byte == 8'd0);
        o_status.too_long    = (prod > CmpW'(LED_COUNT));
        o_status.pix_last    = (r_cnt == (r_scale - 4'd1));
        o_status.final_pixel = (r_pixels_left <= 8'd1);
        o_status.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version   <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_version <= i_cfg_wr_data;
            end
            if (i_cmd.emit_pixel || i_cmd.emit_error) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_scale) begin
            r_scale <= i_stream_byte[3:0];
        end
        if (i_cmd.load_length) begin
            r_pixels_left <= i_stream_byte;
            r_base        <= 7'd0;
        end
        if (i_cmd.load_red) begin
            r_red_hold <= i_stream_byte;
        end
        if (i_cmd.load_green) begin
            r_green_hold <= i_stream_byte;
        end
        if (i_cmd.load_blue) begin
            r_blue_hold <= i_stream_byte;
            r_cnt       <= 4'd0;
        end
        if (i_cmd.emit_pixel) begin
            r_kind  <= lfd_pkg::KIND_PIXEL;
            r_index <= r_base + 7'(r_cnt);
            r_red   <= r_red_hold;
            r_green <= r_green_hold;
            r_blue  <= r_blue_hold;
            r_done  <= o_status.pix_last && o_status.final_pixel;
            r_last  <= o_status.pix_last;
            r_cnt   <= r_cnt + 4'd1;
            if (o_status.pix_last) begin
                r_base        <= r_base + 7'(r_scale);
                r_pixels_left <= r_pixels_left - 8'd1;
            end
        end else if (i_cmd.emit_error) begin
            r_kind  <= i_cmd.err_kind;
            r_index <= 7'd0;
            r_red   <= 8'd0;
            r_green <= 8'd0;
            r_blue  <= 8'd0;
            r_done  <= 1'b0;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_led_index  = r_index;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_frame_done = r_done;
    assign o_last       = r_last;

`ifndef NO_ASSERTIONS
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_pixel |-> (r_cnt < r_scale))
        else $error("pixel count beyond scale");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_last)
        else $error("frame_done without last");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_pixel || i_cmd.emit_error) |-> out_free)
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

/* src/lfd_ctrl.sv */
// Deframer controller: parse-phase state machine and pixel fan-out sequencing.
// Depends on lfd_pkg.
`default_nettype none

module lfd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  lfd_pkg::t_dp_status  i_status,
    output logic                 o_in_ready,
    output lfd_pkg::t_dp_cmd     o_cmd
);

    lfd_pkg::t_state r_state;
    lfd_pkg::t_state n_state;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfd_pkg::ST_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.err_kind = lfd_pkg::KIND_PIXEL;
        o_in_ready = i_rst_n && (r_state != lfd_pkg::ST_EMIT) && i_status.out_free;
        accept     = i_in_valid && o_in_ready;
        case (r_state)
            lfd_pkg::ST_HEADER: begin
                if (accept) begin
                    if (!i_status.version_ok) begin
                        o_cmd.emit_error = 1'b1;
                        o_cmd.err_kind   = lfd_pkg::KIND_VERSION;
                    end else if (i_status.scale_zero) begin
                        o_cmd.emit_error = 1'b1;
                        o_cmd.err_kind   = lfd_pkg::KIND_SCALE;
                    end else begin
                        o_cmd.load_scale = 1'b1;
                        n_state          = lfd_pkg::ST_LENGTH;
                    end
                end
            end
            lfd_pkg::ST_LENGTH: begin
                if (accept) begin
                    if (i_status.length_zero) begin
                        o_cmd.emit_error = 1'b1;
                        o_cmd.err_kind   = lfd_pkg::KIND_LENGTH;
                        n_state          = lfd_pkg::ST_HEADER;
                    end else if (i_status.too_long) begin
                        o_cmd.emit_error = 1'b1;
                        o_cmd.err_kind   = lfd_pkg::KIND_TOOLONG;
                        n_state          = lfd_pkg::ST_HEADER;
                    end else begin
                        o_cmd.load_length = 1'b1;
                        n_state           = lfd_pkg::ST_RED;
                    end
                end
            end
            lfd_pkg::ST_RED: begin
                if (accept) begin
                    o_cmd.load_red = 1'b1;
                    n_state        = lfd_pkg::ST_GREEN;
                end
            end
            lfd_pkg::ST_GREEN: begin
                if (accept) begin
                    o_cmd.load_green = 1'b1;
                    n_state          = lfd_pkg::ST_BLUE;
                end
            end
            lfd_pkg::ST_BLUE: begin
                if (accept) begin
                    o_cmd.load_blue = 1'b1;
                    n_state         = lfd_pkg::ST_EMIT;
                end
            end
            lfd_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_pixel = 1'b1;
                    if (i_status.pix_last) begin
                        n_state = i_status.final_pixel ? lfd_pkg::ST_HEADER
                                                       : lfd_pkg::ST_RED;
                    end
                end
            end
            default: begin
                n_state = lfd_pkg::ST_HEADER;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_scale, o_cmd.load_length, o_cmd.load_red, o_cmd.load_green,
                  o_cmd.load_blue, o_cmd.emit_pixel, o_cmd.emit_error}))
        else $error("more than one datapath command");
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_pixel |-> !o_in_ready)
        else $error("input taken during pixel fan-out");
    a_blue_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_blue |=> (r_state == lfd_pkg::ST_EMIT))
        else $error("blue byte did not start fan-out");
`endif

endmodule

`default_nettype wire

/* src/led_frame_stream_deframer_unit.sv */
// LED frame stream deframer, top level.
// Header, length, red and green bytes are taken only while the result register is free; an
// error result is out in the cycle after its byte. A blue byte starts a fan-out of scale
// pixel results through the single result register, with no byte taken until it is done.
// Synchronous active-low reset: parser waits for a header, version register is 0.
// Depends on lfd_pkg, lfd_if, lfd_datapath and lfd_ctrl.
`default_nettype none

module led_frame_stream_deframer_unit #(
    parameter int LED_COUNT = 128
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire  [3:0]   i_cfg_wr_data,
    lfd_byte_if.sink     i_in,
    lfd_result_if.source o_out
);

    lfd_pkg::t_dp_cmd    cmd;
    lfd_pkg::t_dp_status status;
    logic                in_ready;

    lfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    lfd_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stream_byte (i_in.stream_byte),
        .i_out_ready   (o_out.ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out.valid),
        .o_kind        (o_out.kind),
        .o_led_index   (o_out.led_index),
        .o_red         (o_out.red),
        .o_green       (o_out.green),
        .o_blue        (o_out.blue),
        .o_frame_done  (o_out.frame_done),
        .o_last        (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
